/* hdl/jmet_pkg.sv */
// Shared constants and types for the escape-time iterator.
package jmet_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COORD_WIDTH = 32;

  // z must hold any start point and any value inside radius two.
  localparam int Z_WIDTH   = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3;
  localparam int PROD_WIDTH = 2 * Z_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;
  localparam int MAG_WIDTH  = PROD_WIDTH + 1;

  localparam int LIMIT_WIDTH    = 8;
  localparam int CFG_IDX_WIDTH  = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CONST_REAL = 2'd0,
    REG_CONST_IMAG = 2'd1,
    REG_ITER_LIMIT = 2'd2
  } reg_idx_e;

  localparam logic [COORD_WIDTH-1:0] CONST_REAL_RST = COORD_WIDTH'(75161928);
  localparam logic [COORD_WIDTH-1:0] CONST_IMAG_RST = COORD_WIDTH'(2147484);
  localparam logic [LIMIT_WIDTH-1:0] ITER_LIMIT_RST = LIMIT_WIDTH'(100);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bound_esc;
    logic mag_esc;
  } dp_status_t;

endpackage

/* hdl/julia_mandelbrot_escape_time.sv */
// Top level: configuration registers, controller and datapath.
//
// Escape-time iterator for Julia and Mandelbrot sets, signed fixed point.
// Input: a point (point_real_i, point_imag_i) is taken at a clock edge with
// start high and busy low. Output: escape_count_o is shown for one cycle
// with valid_o high; there is one result per point and the receiver
// cannot stall, so nothing waits on the output side.
// Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_index_i picks
// 0 const_real, 1 const_imag, 2 iteration_limit; other indexes are
// ignored. cfg_ready_o is always high. Both constants zero selects
// Mandelbrot mode (z starts at 0, c is the point).
// Timing: each iteration passes the ST_MUL state, which registers the
// products of the three squaring multipliers, and then the ST_STEP state,
// which runs the update adders and escape compares. busy stays high until
// the result is registered, and the next point can be started in the
// cycle that valid_o is high.
// Reset: asynchronous, clears the sequencer and loads the register defaults.
module julia_mandelbrot_escape_time (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]      point_real_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]      point_imag_i,
  output logic                                  valid_o,
  output logic [jmet_pkg::LIMIT_WIDTH-1:0]      escape_count_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [jmet_pkg::CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]      cfg_data_i
);

  logic [jmet_pkg::COORD_WIDTH-1:0] const_real_q, const_imag_q;
  logic [jmet_pkg::LIMIT_WIDTH-1:0] iter_limit_q;
  jmet_pkg::dp_cmd_t                cmd;
  jmet_pkg::dp_status_t             status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_real_q <= jmet_pkg::CONST_REAL_RST;
      const_imag_q <= jmet_pkg::CONST_IMAG_RST;
      iter_limit_q <= jmet_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        jmet_pkg::REG_CONST_REAL: const_real_q <= cfg_data_i;
        jmet_pkg::REG_CONST_IMAG: const_imag_q <= cfg_data_i;
        jmet_pkg::REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[jmet_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  jmet_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .iter_limit_i   (iter_limit_q),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .valid_o        (valid_o),
    .escape_count_o (escape_count_o)
  );

  jmet_dp u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .point_real_i (point_real_i),
    .point_imag_i (point_imag_i),
    .const_real_i (const_real_q),
    .const_imag_i (const_imag_q),
    .status_o     (status)
  );

endmodule

/* hdl/jmet_dp.sv */
// Datapath: z and c registers, squaring multipliers, update and escape tests.
module jmet_dp (
  input  logic                                clk_i,
  input  jmet_pkg::dp_cmd_t                   cmd_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]    point_real_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]    point_imag_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]    const_real_i,
  input  logic [jmet_pkg::COORD_WIDTH-1:0]    const_imag_i,
  output jmet_pkg::dp_status_t                status_o
);

  localparam int ZW = jmet_pkg::Z_WIDTH;
  localparam int PW = jmet_pkg::PROD_WIDTH;
  localparam int SW = jmet_pkg::SUM_WIDTH;
  localparam int MW = jmet_pkg::MAG_WIDTH;
  localparam int F  = jmet_pkg::FRAC_BITS;

  localparam logic signed [SW-1:0] BOUND  = SW'(1) <<< (F + 1);
  localparam logic signed [MW-1:0] MAG_TH = MW'(1) <<< (2 * F + 2);

  logic signed [ZW-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q;
  logic signed [ZW-1:0] px, py, kr, ki;
  logic signed [SW-1:0] nr, ni;
  logic signed [MW-1:0] mag;
  logic                 mandel;

  assign px = ZW'($signed(point_real_i));
  assign py = ZW'($signed(point_imag_i));
  assign kr = ZW'($signed(const_real_i));
  assign ki = ZW'($signed(const_imag_i));
  assign mandel = (const_real_i == '0) && (const_imag_i == '0);

  // next z from the registered products
  assign nr = SW'(prr_q >>> F) - SW'(pii_q >>> F) + SW'(cr_q);
  assign ni = SW'(pri_q >>> (F - 1)) + SW'(ci_q);
  // |z|^2 of the current z; squares are the same products
  assign mag = MW'(prr_q) + MW'(pii_q);

  assign status_o.bound_esc = (nr > BOUND) || (nr < -BOUND)
                           || (ni > BOUND) || (ni < -BOUND);
  assign status_o.mag_esc   = mag > MAG_TH;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (mandel) begin
        zr_q <= '0;
        zi_q <= '0;
        cr_q <= px;
        ci_q <= py;
      end else begin
        zr_q <= px;
        zi_q <= py;
        cr_q <= kr;
        ci_q <= ki;
      end
    end else if (cmd_i.step) begin
      zr_q <= nr[ZW-1:0];
      zi_q <= ni[ZW-1:0];
    end
    if (cmd_i.mul) begin
      prr_q <= PW'(zr_q) * PW'(zr_q);
      pii_q <= PW'(zi_q) * PW'(zi_q);
      pri_q <= PW'(zr_q) * PW'(zi_q);
    end
  end

endmodule

/* hdl/jmet_ctrl.sv */
// Controller: iteration sequencer, iteration counter and result register.
module jmet_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [jmet_pkg::LIMIT_WIDTH-1:0]    iter_limit_i,
  input  jmet_pkg::dp_status_t                status_i,
  output jmet_pkg::dp_cmd_t                   cmd_o,
  output logic                                busy,
  output logic                                valid_o,
  output logic [jmet_pkg::LIMIT_WIDTH-1:0]    escape_count_o
);

  localparam int LW = jmet_pkg::LIMIT_WIDTH;

  jmet_pkg::state_e state_q, state_d;
  logic [LW-1:0]    iter_q, iter_d;
  logic             prev_q, prev_d;   // z has been updated at least once
  logic             valid_q, valid_d;
  logic [LW-1:0]    count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jmet_pkg::ST_IDLE;
      iter_q  <= '0;
      prev_q  <= 1'b0;
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      prev_q  <= prev_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    prev_d  = prev_q;
    valid_d = 1'b0;
    count_d = count_q;
    cmd_o   = '0;
    unique case (state_q)
      jmet_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          prev_d     = 1'b0;
          state_d    = jmet_pkg::ST_MUL;
        end
      end
      jmet_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = jmet_pkg::ST_STEP;
      end
      jmet_pkg::ST_STEP: begin
        // magnitude test belongs to the previous iteration
        if (prev_q && status_i.mag_esc) begin
          valid_d = 1'b1;
          count_d = iter_q - LW'(1);
          state_d = jmet_pkg::ST_IDLE;
        end else if (iter_q == iter_limit_i) begin
          valid_d = 1'b1;
          count_d = iter_limit_i;
          state_d = jmet_pkg::ST_IDLE;
        end else if (status_i.bound_esc) begin
          valid_d = 1'b1;
          count_d = iter_q;
          state_d = jmet_pkg::ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          iter_d     = iter_q + LW'(1);
          prev_d     = 1'b1;
          state_d    = jmet_pkg::ST_MUL;
        end
      end
      default: state_d = jmet_pkg::ST_IDLE;
    endcase
  end

  assign busy           = (state_q != jmet_pkg::ST_IDLE);
  assign valid_o        = valid_q;
  assign escape_count_o = count_q;

endmodule

/* bench/escape_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the escape-time iterator: register mirror, escape predictor, result check.
package escape_scoreboard_pkg;
  import jmet_pkg::*;

  class escape_scoreboard;
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
    logic [LIMIT_WIDTH-1:0]        iter_limit;
    logic [LIMIT_WIDTH-1:0]        count_q[$];
    logic [2*COORD_WIDTH-1:0]      point_q[$];
    int                            mismatches;

    function new();
      c_real     = CONST_REAL_RST;
      c_imag     = CONST_IMAG_RST;
      iter_limit = ITER_LIMIT_RST;
      mismatches = 0;
    endfunction

    // Mirror of one register-write transaction; unknown indexes change nothing.
    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] data);
      case (idx)
        REG_CONST_REAL: c_real = data;
        REG_CONST_IMAG: c_imag = data;
        REG_ITER_LIMIT: iter_limit = data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function logic [LIMIT_WIDTH-1:0] escape_iter(logic signed [COORD_WIDTH-1:0] p_re,
                                                 logic signed [COORD_WIDTH-1:0] p_im);
      logic signed [127:0] zr, zi, cr, ci, nr, ni, mag, bound, mag_max;
      bound   = 128'sd1 << (FRAC_BITS + 1);
      mag_max = 128'sd1 << (2 * FRAC_BITS + 2);
      cr = 128'(c_real);
      ci = 128'(c_imag);
      // both constants zero: Mandelbrot, z starts at the origin and c is the point
      if (c_real == 0 && c_imag == 0) begin
        zr = '0;
        zi = '0;
        cr = 128'(p_re);
        ci = 128'(p_im);
      end else begin
        zr = 128'(p_re);
        zi = 128'(p_im);
      end
      for (int n = 0; n < int'(iter_limit); n++) begin
        nr = ((zr * zr) >>> FRAC_BITS) - ((zi * zi) >>> FRAC_BITS) + cr;
        ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
        if (nr > bound || nr < -bound || ni > bound || ni < -bound)
          return LIMIT_WIDTH'(n);
        zr  = nr;
        zi  = ni;
        mag = zr * zr + zi * zi;
        if (mag > mag_max)
          return LIMIT_WIDTH'(n);
      end
      return iter_limit;
    endfunction

    function void note_point(logic [COORD_WIDTH-1:0] p_re, logic [COORD_WIDTH-1:0] p_im);
      count_q.push_back(escape_iter(p_re, p_im));
      point_q.push_back({p_re, p_im});
    endfunction

    function void check_count(logic [LIMIT_WIDTH-1:0] got);
      logic [LIMIT_WIDTH-1:0]   want;
      logic [2*COORD_WIDTH-1:0] pt;
      if (count_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: escape_count %0d with no point pending", got);
        return;
      end
      want = count_q.pop_front();
      pt   = point_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: point (%h, %h) escape_count expected %0d actual %0d",
                   pt[2*COORD_WIDTH-1:COORD_WIDTH], pt[COORD_WIDTH-1:0], want, got);
      end
    endfunction

    function int pending();
      return count_q.size();
    endfunction

    function int error_count();
      if (count_q.size() != 0)
        $display("%0d points never produced a result", count_q.size());
      return mismatches + count_q.size();
    endfunction
  endclass

endpackage

/* bench/tb_julia_mandelbrot_escape_time.sv */
`timescale 1ns / 100ps
// Testbench top: drives points and register writes into the escape-time iterator.
module tb_julia_mandelbrot_escape_time;
  import jmet_pkg::*;
  import escape_scoreboard_pkg::*;

  localparam int TIMEOUT_CYCLES = 10_000_000;
  localparam int RAND_PHASES    = 16;
  localparam int PHASE_ITEMS    = 106;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam logic [COORD_WIDTH-1:0] TWO     = 32'h2000_0000;  // 2.0 in Q4.28
  localparam logic [COORD_WIDTH-1:0] ONE     = 32'h1000_0000;
  localparam logic [COORD_WIDTH-1:0] HALF    = 32'h0800_0000;
  localparam logic [COORD_WIDTH-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [COORD_WIDTH-1:0] MAX_NEG = 32'h8000_0000;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic [COORD_WIDTH-1:0]   point_real_i   = '0;
  logic [COORD_WIDTH-1:0]   point_imag_i   = '0;
  logic                     valid_o;
  logic [LIMIT_WIDTH-1:0]   escape_count_o;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i    = '0;
  logic [COORD_WIDTH-1:0]   cfg_data_i     = '0;

  escape_scoreboard sb;
  int               cycle_count = 0;
  int               idle_pct    = 0;
  int               cur_limit   = int'(ITER_LIMIT_RST);

  julia_mandelbrot_escape_time u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .point_real_i   (point_real_i),
    .point_imag_i   (point_imag_i),
    .valid_o        (valid_o),
    .escape_count_o (escape_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (valid_o)
        sb.check_count(escape_count_o);
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(cfg_index_i, cfg_data_i);
      if (start && !busy)
        sb.note_point(point_real_i, point_imag_i);
    end
  end

  // start stays high into the next transaction unless a gap is taken
  task automatic send_point(input logic [COORD_WIDTH-1:0] re, input logic [COORD_WIDTH-1:0] im);
    start        <= 1'b1;
    point_real_i <= re;
    point_imag_i <= im;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2 * cur_limit + 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [COORD_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(input logic [COORD_WIDTH-1:0] c_re,
                            input logic [COORD_WIDTH-1:0] c_im,
                            input logic [LIMIT_WIDTH-1:0] lim);
    logic [COORD_WIDTH-1:0] lim_word;
    lim_word = $urandom;  // upper bits are don't-care
    lim_word[LIMIT_WIDTH-1:0] = lim;
    write_reg(REG_CONST_REAL, c_re);
    write_reg(REG_CONST_IMAG, c_im);
    write_reg(REG_ITER_LIMIT, lim_word);
    if ($urandom_range(3) == 0)
      write_reg(REG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
    cur_limit = int'(lim);
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord(input int kind);
    case (kind)
      0, 1, 2, 3, 4, 5: return $urandom_range(2 * TWO) - TWO;
      6: return $urandom_range(2 * HALF) - HALF;
      7: begin
        case ($urandom_range(4))
          0: return MAX_NEG;
          1: return MAX_POS;
          2: return TWO;
          3: return -TWO;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("tb_julia_mandelbrot_escape_time: done, errors");
    $finish;
  end

  initial begin
    logic [COORD_WIDTH-1:0] c_re, c_im;
    logic [LIMIT_WIDTH-1:0] lim;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset constants: Julia mode, limit 100
    send_point('0, '0);
    send_point(MAX_POS, MAX_POS);
    send_point(MAX_NEG, MAX_NEG);
    send_point(MAX_POS, MAX_NEG);
    send_point(MAX_NEG, MAX_POS);
    send_point(TWO, '0);
    send_point(-TWO, '0);
    send_point('0, TWO);
    send_point(32'h0010_0000, 32'hfff0_0000);
    send_point(TWO + 1, '0);
    drain();

    // Mandelbrot at the largest limit; the origin, c = -2 and the cusp never escape
    set_config('0, '0, 8'd255);
    send_point('0, '0);
    send_point(-TWO, '0);
    send_point(32'h0400_0000, '0);
    send_point(MAX_POS, MAX_POS);
    send_point(MAX_NEG, '0);
    drain();

    // only the real constant zero: still Julia
    set_config('0, 32'h0c00_0000, 8'd1);
    send_point('0, '0);
    send_point(TWO, TWO);
    send_point(MAX_NEG, MAX_POS);
    drain();

    // zero limit: loop never runs
    set_config(MAX_POS, MAX_NEG, 8'd0);
    send_point('0, '0);
    send_point(MAX_POS, MAX_NEG);
    drain();

    set_config(MAX_NEG, MAX_POS, 8'd17);
    send_point('0, '0);
    send_point(32'h0000_0001, 32'hffff_ffff);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case ($urandom_range(5))
        0: begin
          c_re = '0;
          c_im = '0;
        end
        1: begin
          c_re = $urandom_range(2 * ONE) - ONE;
          c_im = $urandom_range(2 * ONE) - ONE;
        end
        2: begin
          c_re = '0;
          c_im = $urandom_range(2 * ONE) - ONE;
        end
        3: begin
          c_re = $urandom_range(2 * ONE) - ONE;
          c_im = '0;
        end
        4: begin
          c_re = $urandom;
          c_im = $urandom;
        end
        default: begin
          c_re = $urandom_range(1) ? MAX_POS : MAX_NEG;
          c_im = $urandom_range(1) ? MAX_POS : MAX_NEG;
        end
      endcase
      if (ph == 0)
        lim = 8'd255;
      else if (ph == 1)
        lim = 8'd0;
      else if (ph == 2)
        lim = 8'd1;
      else if ($urandom_range(3) == 0)
        lim = LIMIT_WIDTH'($urandom_range(255));
      else
        lim = LIMIT_WIDTH'($urandom_range(2, 40));
      set_config(c_re, c_im, lim);
      idle_pct = (ph % 4 == 1) ? 65 : (ph % 4 == 3) ? 21 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_point(rand_coord($urandom_range(9)), rand_coord($urandom_range(9)));
    end

    drain();
    repeat (2 * cur_limit + 8) @(posedge clk_i);
    if (sb.error_count() == 0)
      $display("tb_julia_mandelbrot_escape_time: done, clean");
    else
      $display("tb_julia_mandelbrot_escape_time: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hdl/jmet_pkg.sv
hdl/jmet_dp.sv
hdl/jmet_ctrl.sv
hdl/julia_mandelbrot_escape_time.sv
bench/escape_scoreboard_pkg.sv
bench/tb_julia_mandelbrot_escape_time.sv
